// File: hdl/rctenc_pkg.sv
package rctenc_pkg;

    localparam int SAMPLE_W     = 8;
    localparam int COMP_W       = 9;
    localparam int NUM_COMP     = 4;
    localparam int NUM_COLOR    = 3;
    localparam int PRED_W       = 3;
    localparam int WIDTH_W      = 13;
    localparam int CFG_W        = 13;
    localparam int CFG_INDEX_W  = 2;
    localparam int CAT_W        = 4;
    localparam int TCODE_W      = 11;
    localparam int TSIZE_W      = 4;
    localparam int CODE_W       = 18;
    localparam int COUNT_W      = 5;
    localparam int COMP_ID_W    = 2;

    localparam logic [COMP_W-1:0]  HALF_RANGE    = 9'h100;
    localparam logic [COMP_W-1:0]  CHROMA_OFFSET = 9'h100;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET   = 13'd4096;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PREDICTOR = 2'd0,
        REG_ALPHA     = 2'd1,
        REG_WIDTH     = 2'd2
    } cfg_reg_t;

    // Lossless JPEG predictor numbers. Zero and seven share the average.
    localparam logic [PRED_W-1:0] PRED_LEFT       = 3'd1;
    localparam logic [PRED_W-1:0] PRED_ABOVE      = 3'd2;
    localparam logic [PRED_W-1:0] PRED_ABOVE_LEFT = 3'd3;
    localparam logic [PRED_W-1:0] PRED_PLANE      = 3'd4;
    localparam logic [PRED_W-1:0] PRED_LEFT_HALF  = 3'd5;
    localparam logic [PRED_W-1:0] PRED_ABOVE_HALF = 3'd6;

    localparam logic [COMP_ID_W-1:0] COMP_Y     = 2'd0;
    localparam logic [COMP_ID_W-1:0] COMP_CB    = 2'd1;
    localparam logic [COMP_ID_W-1:0] COMP_CR    = 2'd2;
    localparam logic [COMP_ID_W-1:0] COMP_ALPHA = 2'd3;

    typedef struct packed {
        logic [SAMPLE_W-1:0] blue;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] alpha;
        logic                frame_start;
    } pixel_t;

    typedef struct packed {
        logic [CODE_W-1:0]    code_bits;
        logic [COUNT_W-1:0]   bit_count;
        logic [COMP_ID_W-1:0] component;
        logic                 last_of_pixel;
    } code_t;

    // One coded component before it is tagged for the output channel.
    typedef struct packed {
        logic [CODE_W-1:0]  code_bits;
        logic [COUNT_W-1:0] bit_count;
    } word_t;

    // Hand-over of a coded pixel to the output queue.
    typedef struct packed {
        logic load;
        logic four;
    } push_t;

    function automatic logic [TCODE_W-1:0] luma_code(input logic [CAT_W-1:0] cat);
        case (cat)
            4'd0:    return 11'h000;
            4'd1:    return 11'h002;
            4'd2:    return 11'h003;
            4'd3:    return 11'h004;
            4'd4:    return 11'h005;
            4'd5:    return 11'h006;
            4'd6:    return 11'h00E;
            4'd7:    return 11'h01E;
            4'd8:    return 11'h03E;
            4'd9:    return 11'h07E;
            4'd10:   return 11'h0FE;
            4'd11:   return 11'h1FE;
            default: return 11'h000;
        endcase
    endfunction

    function automatic logic [TSIZE_W-1:0] luma_size(input logic [CAT_W-1:0] cat);
        case (cat)
            4'd0:    return 4'd2;
            4'd1:    return 4'd3;
            4'd2:    return 4'd3;
            4'd3:    return 4'd3;
            4'd4:    return 4'd3;
            4'd5:    return 4'd3;
            4'd6:    return 4'd4;
            4'd7:    return 4'd5;
            4'd8:    return 4'd6;
            4'd9:    return 4'd7;
            4'd10:   return 4'd8;
            4'd11:   return 4'd9;
            default: return 4'd0;
        endcase
    endfunction

    function automatic logic [TCODE_W-1:0] chroma_code(input logic [CAT_W-1:0] cat);
        case (cat)
            4'd0:    return 11'h000;
            4'd1:    return 11'h001;
            4'd2:    return 11'h002;
            4'd3:    return 11'h006;
            4'd4:    return 11'h00E;
            4'd5:    return 11'h01E;
            4'd6:    return 11'h03E;
            4'd7:    return 11'h07E;
            4'd8:    return 11'h0FE;
            4'd9:    return 11'h1FE;
            4'd10:   return 11'h3FE;
            4'd11:   return 11'h7FE;
            default: return 11'h000;
        endcase
    endfunction

    function automatic logic [TSIZE_W-1:0] chroma_size(input logic [CAT_W-1:0] cat);
        case (cat)
            4'd0:    return 4'd2;
            4'd1:    return 4'd2;
            4'd2:    return 4'd2;
            4'd3:    return 4'd3;
            4'd4:    return 4'd4;
            4'd5:    return 4'd5;
            4'd6:    return 4'd6;
            4'd7:    return 4'd7;
            4'd8:    return 4'd8;
            4'd9:    return 4'd9;
            4'd10:   return 4'd10;
            4'd11:   return 4'd11;
            default: return 4'd0;
        endcase
    endfunction

endpackage

// File: hdl/lossless_jpeg_rct_pixel_encoder.sv
// Lossless predictive pixel encoder with a reversible color transform. Pixels
// enter as BGRA beats in raster order; each is turned into Y, Cb and Cr (and
// alpha when enabled), predicted from its left, above and above-left
// neighbors, and coded with the JPEG DC Huffman category code followed by the
// magnitude bits. One output beat carries one codeword, in component order, with
// last_of_pixel set on the final one. A pixel waits in the input register while
// the coding logic works on it, until the result register is free to load; its
// codewords are then registered there and handed out in order. The single
// output channel sets the rate: a pixel yields three codewords with alpha off
// and four with alpha on, one per output beat, and a stall holds the one not yet
// accepted. The input register accepts the next pixel while codewords of the
// previous one are still being drained. The previous row lives in two
// simple-dual-port RAMs (color and alpha, MAX_WIDTH entries each) plus a row
// start register; no clearing pass is needed after reset. Configuration is
// written through cfg_write, cfg_index and cfg_data while the block is idle:
// index 0 selects the predictor used after the first row, index 1 enables
// alpha coding, and index 2 sets the row width, where zero or a width above
// MAX_WIDTH means MAX_WIDTH.
module lossless_jpeg_rct_pixel_encoder
    import rctenc_pkg::*;
    #(
        parameter int MAX_WIDTH = 4096
    )
    (
        input  logic                    clk,
        input  logic                    rst_n,
        input  logic                    cfg_write,
        input  logic [CFG_INDEX_W-1:0]  cfg_index,
        input  logic [CFG_W-1:0]        cfg_data,
        input  logic                    pixel_valid,
        output logic                    pixel_ready,
        input  pixel_t                  pixel,
        output logic                    code_valid,
        input  logic                    code_ready,
        output code_t                   code
    );

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int CNT_W  = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W  = (CNT_W > WIDTH_W) ? CNT_W : WIDTH_W;
    localparam int COLOR_W = NUM_COLOR * COMP_W;

    // Configuration registers.
    logic [PRED_W-1:0]  pred_reg;
    logic               alpha_en_reg;
    logic [WIDTH_W-1:0] width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pred_reg     <= PRED_LEFT;
            alpha_en_reg <= 1'b0;
            width_reg    <= WIDTH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PREDICTOR: pred_reg     <= cfg_data[PRED_W-1:0];
                REG_ALPHA:     alpha_en_reg <= cfg_data[0];
                REG_WIDTH:     width_reg    <= cfg_data[WIDTH_W-1:0];
                default:       ;
            endcase
        end
    end

    // Input register. It frees up as soon as the coding stage takes its pixel.
    pixel_t stage_reg;
    logic   stage_valid_reg;
    logic   can_load;
    logic   fire;

    assign fire        = stage_valid_reg && can_load;
    assign pixel_ready = !stage_valid_reg || can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (pixel_valid && pixel_ready)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel_valid && pixel_ready)
        begin
            stage_reg <= pixel;
        end
    end

    // Neighbor state. The row start register holds the first pixel of the
    // previous row; the RAMs hold the rest of that row, entry k standing for
    // column k + 1.
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic              first_row_reg;
    logic              first_row_next;
    logic [COMP_W-1:0] left_reg [NUM_COMP];
    logic [COMP_W-1:0] left_next [NUM_COMP];
    logic [COMP_W-1:0] abl_reg [NUM_COMP];
    logic [COMP_W-1:0] abl_next [NUM_COMP];
    logic [COMP_W-1:0] row0_reg [NUM_COMP];
    logic [COMP_W-1:0] row0_next [NUM_COMP];
    logic [COMP_W-1:0] alpha_above_reg;
    logic [COMP_W-1:0] alpha_above_next;
    logic              alpha_from_ram_reg;
    logic              alpha_from_ram_next;

    // Current pixel in the coding stage.
    logic [COMP_W-1:0]   comp [NUM_COMP];
    logic [COMP_W-1:0]   row0_eff [NUM_COMP];
    logic [COMP_W-1:0]   above_eff [NUM_COMP];
    logic [COMP_W-1:0]   a_use [NUM_COMP];
    logic [COMP_W-1:0]   b_use [NUM_COMP];
    logic [COMP_W-1:0]   c_use [NUM_COMP];
    logic [SAMPLE_W+1:0] luma_sum;
    logic [COL_W-1:0]    col_eff;
    logic                row_start;
    logic                first_row_eff;
    logic [PRED_W-1:0]   sel;
    logic [CMP_W-1:0]    width_ext;
    logic [CMP_W-1:0]    width_eff;
    logic [CMP_W-1:0]    col_inc;
    logic [COLOR_W-1:0]  color_q;
    logic [SAMPLE_W-1:0] alpha_q;
    word_t               words [NUM_COMP];
    push_t               push;

    // Reversible color transform. Cb and Cr stay within nine bits.
    assign luma_sum = (SAMPLE_W + 2)'(stage_reg.blue) + (SAMPLE_W + 2)'(stage_reg.red)
                    + {1'b0, stage_reg.green, 1'b0};
    assign comp[COMP_Y]     = COMP_W'(luma_sum[SAMPLE_W+1:2]);
    assign comp[COMP_CB]    = COMP_W'(stage_reg.blue) + CHROMA_OFFSET
                            - COMP_W'(stage_reg.green);
    assign comp[COMP_CR]    = COMP_W'(stage_reg.red) + CHROMA_OFFSET
                            - COMP_W'(stage_reg.green);
    assign comp[COMP_ALPHA] = COMP_W'(stage_reg.alpha);

    // A frame start clears the position before the pixel is coded.
    assign col_eff       = stage_reg.frame_start ? '0 : col_reg;
    assign row_start     = (col_eff == '0);
    assign first_row_eff = stage_reg.frame_start || first_row_reg;
    assign sel           = first_row_eff ? PRED_LEFT : pred_reg;

    assign width_ext = CMP_W'(width_reg);
    assign width_eff = ((width_reg == '0) || (width_ext > CMP_W'(MAX_WIDTH)))
                     ? CMP_W'(MAX_WIDTH) : width_ext;
    assign col_inc   = CMP_W'(col_eff) + CMP_W'(1);

    // Above values for the color components always come from the RAM read that
    // the previous pixel issued. Alpha keeps its own copy because that read is
    // skipped while alpha is disabled.
    always_comb
    begin
        for (int i = 0; i < NUM_COMP; i++)
        begin
            row0_eff[i] = stage_reg.frame_start ? HALF_RANGE : row0_reg[i];
        end
        for (int i = 0; i < NUM_COLOR; i++)
        begin
            above_eff[i] = color_q[i*COMP_W +: COMP_W];
        end
        above_eff[COMP_ALPHA] = alpha_from_ram_reg ? COMP_W'(alpha_q) : alpha_above_reg;
        for (int i = 0; i < NUM_COMP; i++)
        begin
            a_use[i] = row_start ? row0_eff[i] : left_reg[i];
            b_use[i] = row_start ? row0_eff[i] : above_eff[i];
            c_use[i] = row_start ? row0_eff[i] : abl_reg[i];
        end
    end

    // State update for one coded pixel.
    always_comb
    begin
        col_next            = col_reg;
        first_row_next      = first_row_reg;
        left_next           = left_reg;
        abl_next            = abl_reg;
        row0_next           = row0_reg;
        alpha_above_next    = alpha_above_reg;
        alpha_from_ram_next = alpha_from_ram_reg;
        if (fire)
        begin
            for (int i = 0; i < NUM_COLOR; i++)
            begin
                left_next[i] = comp[i];
                abl_next[i]  = b_use[i];
            end
            if (alpha_en_reg)
            begin
                left_next[COMP_ALPHA] = comp[COMP_ALPHA];
                abl_next[COMP_ALPHA]  = b_use[COMP_ALPHA];
                alpha_from_ram_next   = 1'b1;
            end
            else if (row_start)
            begin
                // Alpha is not coded, but the row start still reloads it.
                left_next[COMP_ALPHA] = row0_eff[COMP_ALPHA];
                abl_next[COMP_ALPHA]  = row0_eff[COMP_ALPHA];
                alpha_above_next      = row0_eff[COMP_ALPHA];
                alpha_from_ram_next   = 1'b0;
            end
            row0_next = row0_eff;
            if (row_start)
            begin
                for (int i = 0; i < NUM_COLOR; i++)
                begin
                    row0_next[i] = comp[i];
                end
                if (alpha_en_reg)
                begin
                    row0_next[COMP_ALPHA] = comp[COMP_ALPHA];
                end
            end
            if (col_inc >= width_eff)
            begin
                col_next       = '0;
                first_row_next = 1'b0;
            end
            else
            begin
                col_next       = col_inc[COL_W-1:0];
                first_row_next = first_row_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg            <= '0;
            first_row_reg      <= 1'b1;
            alpha_above_reg    <= HALF_RANGE;
            alpha_from_ram_reg <= 1'b0;
            for (int i = 0; i < NUM_COMP; i++)
            begin
                left_reg[i] <= HALF_RANGE;
                abl_reg[i]  <= HALF_RANGE;
                row0_reg[i] <= HALF_RANGE;
            end
        end
        else
        begin
            col_reg            <= col_next;
            first_row_reg      <= first_row_next;
            left_reg           <= left_next;
            abl_reg            <= abl_next;
            row0_reg           <= row0_next;
            alpha_above_reg    <= alpha_above_next;
            alpha_from_ram_reg <= alpha_from_ram_next;
        end
    end

    // Previous row store. A pixel past the row start writes its own column and reads
    // the next one, which becomes the above value of the following pixel.
    rctenc_ram
        #(
            .DATA_W (COLOR_W),
            .DEPTH  (MAX_WIDTH)
        )
        u_color_ram
        (
            .clk   (clk),
            .we    (fire && !row_start),
            .waddr (col_eff - COL_W'(1)),
            .wdata ({comp[COMP_CR], comp[COMP_CB], comp[COMP_Y]}),
            .re    (fire),
            .raddr (col_eff),
            .rdata (color_q)
        );

    rctenc_ram
        #(
            .DATA_W (SAMPLE_W),
            .DEPTH  (MAX_WIDTH)
        )
        u_alpha_ram
        (
            .clk   (clk),
            .we    (fire && !row_start && alpha_en_reg),
            .waddr (col_eff - COL_W'(1)),
            .wdata (comp[COMP_ALPHA][SAMPLE_W-1:0]),
            .re    (fire && alpha_en_reg),
            .raddr (col_eff),
            .rdata (alpha_q)
        );

    // One predictor and entropy coder per component, all in the same cycle.
    for (genvar g = 0; g < NUM_COMP; g++)
    begin : g_coder
        rctenc_coder u_coder
        (
            .sample     (comp[g]),
            .left       (a_use[g]),
            .above      (b_use[g]),
            .above_left (c_use[g]),
            .predictor  (sel),
            .chroma     ((g == COMP_CB) || (g == COMP_CR)),
            .word       (words[g])
        );
    end

    assign push.load = fire;
    assign push.four = alpha_en_reg;

    // Result register: holds the pixel's codewords and hands them out in order.
    rctenc_outq u_outq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .words      (words),
        .can_load   (can_load),
        .code_valid (code_valid),
        .code_ready (code_ready),
        .code       (code)
    );

endmodule

// File: hdl/rctenc_ram.sv
module rctenc_ram
    #(
        parameter int DATA_W = 8,
        parameter int DEPTH  = 16
    )
    (
        input  logic                      clk,
        input  logic                      we,
        input  logic [$clog2(DEPTH)-1:0]  waddr,
        input  logic [DATA_W-1:0]         wdata,
        input  logic                      re,
        input  logic [$clog2(DEPTH)-1:0]  raddr,
        output logic [DATA_W-1:0]         rdata
    );

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/rctenc_coder.sv
module rctenc_coder
    import rctenc_pkg::*;
    (
        input  logic [COMP_W-1:0]  sample,
        input  logic [COMP_W-1:0]  left,
        input  logic [COMP_W-1:0]  above,
        input  logic [COMP_W-1:0]  above_left,
        input  logic [PRED_W-1:0]  predictor,
        input  logic               chroma,
        output word_t              word
    );

    localparam int ARITH_W = 12;
    localparam int MAG_W   = COMP_W + 1;
    localparam int BITS_W  = TCODE_W + MAG_W - 1;

    logic signed [ARITH_W-1:0] a;
    logic signed [ARITH_W-1:0] b;
    logic signed [ARITH_W-1:0] c;
    logic signed [ARITH_W-1:0] pred;
    logic [ARITH_W-1:0]        diff_full;
    logic [MAG_W-1:0]          res_ext;
    logic [MAG_W-1:0]          mag;
    logic [MAG_W-1:0]          adj;
    logic [MAG_W-1:0]          mant;
    logic [CAT_W-1:0]          cat;
    logic [TCODE_W-1:0]        tcode;
    logic [TSIZE_W-1:0]        tsize;
    logic [BITS_W-1:0]         bits;

    assign a = signed'(ARITH_W'(left));
    assign b = signed'(ARITH_W'(above));
    assign c = signed'(ARITH_W'(above_left));

    // Halved terms use an arithmetic shift, which rounds toward minus infinity.
    always_comb
    begin
        case (predictor)
            PRED_LEFT:       pred = a;
            PRED_ABOVE:      pred = b;
            PRED_ABOVE_LEFT: pred = c;
            PRED_PLANE:      pred = a + b - c;
            PRED_LEFT_HALF:  pred = a + ((b - c) >>> 1);
            PRED_ABOVE_HALF: pred = b + ((a - c) >>> 1);
            default:         pred = (a + b) >>> 1;
        endcase
    end

    // The residual wraps to nine bits, so only its low bits matter.
    assign diff_full = ARITH_W'(sample) - pred;
    assign res_ext   = {diff_full[COMP_W-1], diff_full[COMP_W-1:0]};
    assign mag       = res_ext[MAG_W-1] ? (~res_ext + MAG_W'(1)) : res_ext;
    assign adj       = res_ext[MAG_W-1] ? (res_ext - MAG_W'(1)) : res_ext;

    always_comb
    begin
        cat = '0;
        for (int k = 0; k < MAG_W; k++)
        begin
            if (mag[k])
            begin
                cat = CAT_W'(k + 1);
            end
        end
    end

    assign mant  = adj & ((MAG_W'(1) << cat) - MAG_W'(1));
    assign tcode = chroma ? chroma_code(cat) : luma_code(cat);
    assign tsize = chroma ? chroma_size(cat) : luma_size(cat);
    assign bits  = (BITS_W'(tcode) << cat) | BITS_W'(mant);

    assign word.code_bits = bits[CODE_W-1:0];
    assign word.bit_count = COUNT_W'(tsize) + COUNT_W'(cat);

endmodule

// File: hdl/rctenc_outq.sv
module rctenc_outq
    import rctenc_pkg::*;
    (
        input  logic   clk,
        input  logic   rst_n,
        input  push_t  push,
        input  word_t  words [NUM_COMP],
        output logic   can_load,
        output logic   code_valid,
        input  logic   code_ready,
        output code_t  code
    );

    word_t                word_reg [NUM_COMP];
    logic [COMP_ID_W-1:0] idx_reg;
    logic                 four_reg;
    logic                 busy_reg;
    logic                 last;

    assign last     = four_reg ? (idx_reg == COMP_ALPHA) : (idx_reg == COMP_CR);
    assign can_load = !busy_reg || (code_ready && last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= COMP_Y;
            four_reg <= 1'b0;
        end
        else if (push.load)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= COMP_Y;
            four_reg <= push.four;
        end
        else if (busy_reg && code_ready)
        begin
            if (last)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + COMP_ID_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.load)
        begin
            word_reg <= words;
        end
    end

    assign code_valid         = busy_reg;
    assign code.code_bits     = word_reg[idx_reg].code_bits;
    assign code.bit_count     = word_reg[idx_reg].bit_count;
    assign code.component     = idx_reg;
    assign code.last_of_pixel = last;

endmodule

// File: hdl/rctenc_checker.sv
module rctenc_checker
    import rctenc_pkg::*;
    (
        input logic   clk,
        input logic   rst_n,
        input logic   code_valid,
        input logic   code_ready,
        input code_t  code
    );

    // A codeword that is not taken stays on offer unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && !code_ready |=> code_valid && $stable(code))
    else $error("codeword dropped or changed while stalled");

    // A pixel ends after Cr or after alpha, never earlier.
    assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && code.last_of_pixel |->
            (code.component == COMP_CR) || (code.component == COMP_ALPHA))
    else $error("pixel ended on a wrong component");

    // Within a pixel the components follow each other without a gap.
    assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && code_ready && !code.last_of_pixel |=>
            code_valid && (code.component == $past(code.component) + COMP_ID_W'(1)))
    else $error("component sequence broken within a pixel");

    // A new pixel always starts with luma.
    assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && code_ready && code.last_of_pixel ##1 code_valid |->
            code.component == COMP_Y)
    else $error("pixel did not start with luma");

    // Every codeword carries at least the shortest code and at most eighteen bits.
    assert property (@(posedge clk) disable iff (!rst_n)
        code_valid |-> (code.bit_count >= COUNT_W'(2)) && (code.bit_count <= COUNT_W'(18)))
    else $error("codeword length out of range");

endmodule

bind lossless_jpeg_rct_pixel_encoder rctenc_checker u_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .code_valid (code_valid),
    .code_ready (code_ready),
    .code       (code)
);

// File: sim/rctenc_codeword_check.sv
`timescale 1ns / 1ps

// Watches the configuration port and both channels of the encoder, works out
// the codewords each accepted pixel must produce and compares every output
// beat with the oldest one still owed.
module rctenc_codeword_check
    import rctenc_pkg::*;
    #(
        parameter int MAX_WIDTH = 4096
    )
    (
        input  logic                   clk,
        input  logic                   rst_n,
        input  logic                   cfg_write,
        input  logic [CFG_INDEX_W-1:0] cfg_index,
        input  logic [CFG_W-1:0]       cfg_data,
        input  logic                   pixel_valid,
        input  logic                   pixel_ready,
        input  pixel_t                 pixel,
        input  logic                   code_valid,
        input  logic                   code_ready,
        input  code_t                  code,
        output int                     errors,
        output int                     outstanding
    );

    localparam int WRAP_OFFSET = 256;
    localparam int WRAP_MASK   = 'h1FF;
    localparam int MAX_REPORTS = 10;

    logic [PRED_W-1:0]  pred_sel;
    logic               alpha_on;
    logic [WIDTH_W-1:0] row_width;

    logic [COMP_W-1:0] prev_row [0:MAX_WIDTH][0:NUM_COMP-1];
    int                left_val [NUM_COMP];
    int                up_val [NUM_COMP];
    int                up_left_val [NUM_COMP];
    int                column;
    bit                top_row;

    code_t             owed_codes [$];
    code_t             want;
    int                k;
    int                n;

    function automatic int half_down(input int d);
        return d >>> 1;
    endfunction

    // a = left, b = above, c = above-left.
    function automatic int predicted(input int a, input int b, input int c,
                                     input logic [PRED_W-1:0] sel);
        case (sel)
            PRED_LEFT:       return a;
            PRED_ABOVE:      return b;
            PRED_ABOVE_LEFT: return c;
            PRED_PLANE:      return a + b - c;
            PRED_LEFT_HALF:  return a + half_down(b - c);
            PRED_ABOVE_HALF: return b + half_down(a - c);
            default:         return half_down(a + b);
        endcase
    endfunction

    // Residual category code plus magnitude bits. The DC prefixes are runs of
    // ones closed by a zero once the short codes run out.
    function automatic code_t make_code(input int value, input int guess,
                                        input bit luma_table,
                                        input logic [COMP_ID_W-1:0] comp_id,
                                        input bit final_word);
        int    resid;
        int    mag;
        int    cat;
        int    mant;
        int    prefix;
        int    prefix_len;
        code_t w;
        resid = ((value - guess + WRAP_OFFSET) & WRAP_MASK) - WRAP_OFFSET;
        mag = (resid < 0) ? -resid : resid;
        cat = 0;
        while (cat < 11 && (mag >> cat) != 0)
            cat++;
        mant = ((resid < 0) ? resid - 1 : resid) & ((1 << cat) - 1);
        if (luma_table)
        begin
            if (cat == 0)
            begin
                prefix = 0;
                prefix_len = 2;
            end
            else if (cat <= 5)
            begin
                prefix = cat + 1;
                prefix_len = 3;
            end
            else
            begin
                prefix_len = cat - 2;
                prefix = (1 << prefix_len) - 2;
            end
        end
        else
        begin
            if (cat <= 2)
            begin
                prefix = cat;
                prefix_len = 2;
            end
            else
            begin
                prefix_len = cat;
                prefix = (1 << prefix_len) - 2;
            end
        end
        w.code_bits = CODE_W'((prefix << cat) | mant);
        w.bit_count = COUNT_W'(prefix_len + cat);
        w.component = comp_id;
        w.last_of_pixel = final_word;
        return w;
    endfunction

    task automatic code_pixel(input pixel_t px);
        int comp_val [NUM_COMP];
        int span;
        int ncomp;
        int i;
        int guess;
        logic [PRED_W-1:0] sel;
        span = row_width;
        if (span == 0 || span > MAX_WIDTH)
            span = MAX_WIDTH;
        if (px.frame_start)
        begin
            for (i = 0; i < NUM_COMP; i++)
                prev_row[0][i] = HALF_RANGE;
            column = 0;
            top_row = 1'b1;
        end
        if (column == 0)
        begin
            for (i = 0; i < NUM_COMP; i++)
            begin
                left_val[i] = prev_row[0][i];
                up_val[i] = prev_row[0][i];
                up_left_val[i] = prev_row[0][i];
            end
        end
        comp_val[0] = (int'(px.blue) + 2 * int'(px.green) + int'(px.red)) >> 2;
        comp_val[1] = int'(px.blue) - int'(px.green) + WRAP_OFFSET;
        comp_val[2] = int'(px.red) - int'(px.green) + WRAP_OFFSET;
        comp_val[3] = int'(px.alpha);
        ncomp = alpha_on ? NUM_COMP : NUM_COLOR;
        for (i = 0; i < ncomp; i++)
            prev_row[column][i] = COMP_W'(comp_val[i]);
        sel = top_row ? PRED_LEFT : pred_sel;
        for (i = 0; i < ncomp; i++)
        begin
            guess = predicted(left_val[i], up_val[i], up_left_val[i], sel);
            up_left_val[i] = up_val[i];
            up_val[i] = prev_row[column + 1][i];
            left_val[i] = comp_val[i];
            owed_codes.push_back(make_code(comp_val[i], guess,
                                           (i == COMP_Y) || (i == COMP_ALPHA),
                                           COMP_ID_W'(i), i == ncomp - 1));
        end
        column++;
        if (column >= span)
        begin
            column = 0;
            top_row = 1'b0;
        end
    endtask

    task automatic report(input code_t seen, input bit unexpected);
        if (errors < MAX_REPORTS)
        begin
            if (unexpected)
                $display({"%0t: codeword beat with nothing owed: ",
                          "bits %h count %0d comp %0d last %0d"},
                         $realtime, seen.code_bits, seen.bit_count, seen.component,
                         seen.last_of_pixel);
            else
                $display({"%0t: codeword mismatch: ",
                          "expected bits %h count %0d comp %0d last %0d, ",
                          "got bits %h count %0d comp %0d last %0d"},
                         $realtime, want.code_bits, want.bit_count, want.component,
                         want.last_of_pixel, seen.code_bits, seen.bit_count,
                         seen.component, seen.last_of_pixel);
        end
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pred_sel = PRED_LEFT;
            alpha_on = 1'b0;
            row_width = WIDTH_RESET;
            for (k = 0; k <= MAX_WIDTH; k++)
                for (n = 0; n < NUM_COMP; n++)
                    prev_row[k][n] = '0;
            for (n = 0; n < NUM_COMP; n++)
            begin
                prev_row[0][n] = HALF_RANGE;
                left_val[n] = HALF_RANGE;
                up_val[n] = HALF_RANGE;
                up_left_val[n] = HALF_RANGE;
            end
            column = 0;
            top_row = 1'b1;
            owed_codes.delete();
            outstanding = 0;
            errors = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_PREDICTOR: pred_sel = cfg_data[PRED_W-1:0];
                    REG_ALPHA:     alpha_on = cfg_data[0];
                    REG_WIDTH:     row_width = cfg_data[WIDTH_W-1:0];
                    default:       ;
                endcase
            end
            if (code_valid && code_ready)
            begin
                if (owed_codes.size() == 0)
                begin
                    report(code, 1'b1);
                end
                else
                begin
                    want = owed_codes.pop_front();
                    if (code.code_bits !== want.code_bits
                        || code.bit_count !== want.bit_count
                        || code.component !== want.component
                        || code.last_of_pixel !== want.last_of_pixel)
                        report(code, 1'b0);
                end
            end
            if (pixel_valid && pixel_ready)
                code_pixel(pixel);
            outstanding = owed_codes.size();
        end
    end

endmodule

// File: sim/lossless_jpeg_rct_pixel_encoder_tb.sv
`timescale 1ns / 1ps

// Top of the encoder testbench. It makes the stimulus (configuration writes,
// pixel beats and the output ready) and gives the verdict; all prediction and
// comparison lives in the codeword checker instantiated beside the block.
module lossless_jpeg_rct_pixel_encoder_tb;
    import rctenc_pkg::*;

    localparam int MAX_WIDTH = 4096;
    // Once the last owed codeword is out the block is idle, so a short settle
    // after it is plenty before touching registers.
    localparam int SETTLE_CYCLES = 16;
    // Cycles without any accepted beat before the run is declared hung. The
    // longest legal quiet stretch is a settle plus a few register writes.
    localparam int STALL_LIMIT = 2000;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_W-1:0]       cfg_data;
    logic                   pixel_valid;
    logic                   pixel_ready;
    pixel_t                 pixel;
    logic                   code_valid;
    logic                   code_ready;
    code_t                  code;

    int     errors;
    int     outstanding;
    int     quiet_cycles = 0;
    // Set for the closing part of the run, where neither side idles.
    bit     steady = 1'b0;
    pixel_t last_px = '0;

    lossless_jpeg_rct_pixel_encoder #(
        .MAX_WIDTH (MAX_WIDTH)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel       (pixel),
        .code_valid  (code_valid),
        .code_ready  (code_ready),
        .code        (code)
    );

    rctenc_codeword_check #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_codeword_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel       (pixel),
        .code_valid  (code_valid),
        .code_ready  (code_ready),
        .code        (code),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The watchdog restarts its count on every accepted beat on either
    // channel. Reaching the limit means the block has stopped moving.
    always @(posedge clk)
    begin
        if (!rst_n || (pixel_valid && pixel_ready) || (code_valid && code_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("lossless_jpeg_rct_pixel_encoder_tb: done, errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Output ready: mostly short bursts of ready broken by stalls, now and then a long
    // stretch with no stall at all. Once the run goes steady the ready stays high.
    initial
    begin : ready_gen
        int run;
        code_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (steady)
                run = 1;
            else if ($urandom_range(0, 3) == 0)
                run = $urandom_range(30, 80);
            else
                run = $urandom_range(1, 12);
            code_ready <= 1'b1;
            repeat (run) @(negedge clk);
            if (!steady)
            begin
                code_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
        end
    end

    function automatic pixel_t make_px(input int b, input int g, input int r,
                                       input int a, input bit fs);
        pixel_t px;
        px.blue = SAMPLE_W'(b);
        px.green = SAMPLE_W'(g);
        px.red = SAMPLE_W'(r);
        px.alpha = SAMPLE_W'(a);
        px.frame_start = fs;
        return px;
    endfunction

    // A sample a few steps away from the previous one, so that small residuals
    // and the short codes get plenty of traffic.
    function automatic logic [SAMPLE_W-1:0] sample_near(input logic [SAMPLE_W-1:0] prev);
        int v;
        v = int'(prev) + int'($urandom_range(0, 6)) - 3;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return SAMPLE_W'(v);
    endfunction

    // Mix of smooth, fully random and saturated pixels.
    function automatic pixel_t random_px(input bit fs);
        pixel_t px;
        int     mode;
        mode = $urandom_range(0, 99);
        if (mode < 50)
        begin
            px.blue = sample_near(last_px.blue);
            px.green = sample_near(last_px.green);
            px.red = sample_near(last_px.red);
            px.alpha = sample_near(last_px.alpha);
        end
        else if (mode < 85)
        begin
            px.blue = SAMPLE_W'($urandom);
            px.green = SAMPLE_W'($urandom);
            px.red = SAMPLE_W'($urandom);
            px.alpha = SAMPLE_W'($urandom);
        end
        else
        begin
            px.blue = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            px.red = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            px.alpha = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        px.frame_start = fs;
        last_px = px;
        return px;
    endfunction

    // Called at a falling edge. Raises valid with the payload and holds both
    // until the beat is taken, then returns at the next falling edge with
    // valid still high, so a following beat goes out back to back.
    task automatic push_pixel(input pixel_t px);
        pixel_valid <= 1'b1;
        pixel <= px;
        @(posedge clk);
        while (pixel_ready !== 1'b1)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Random sender idling after a beat; the payload wanders while valid is
    // low, which the block must ignore.
    task automatic pixel_gap(input int gap_pct);
        if (!steady && $urandom_range(0, 99) < gap_pct)
        begin
            pixel_valid <= 1'b0;
            pixel <= make_px($urandom, $urandom, $urandom, $urandom,
                             1'($urandom_range(0, 1)));
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
    endtask

    // Hold the sender until every owed codeword has come out, then let the
    // pipeline settle. Registers are only written after this.
    task automatic drain();
        pixel_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Unused upper bits of the narrow registers carry random junk, which the
    // block has to mask off.
    task automatic configure(input logic [PRED_W-1:0] sel, input bit with_alpha,
                             input logic [CFG_W-1:0] width);
        drain();
        write_reg(REG_PREDICTOR, {10'($urandom), sel});
        write_reg(REG_ALPHA, {12'($urandom), with_alpha});
        write_reg(REG_WIDTH, width);
    endtask

    // One randomized run under a fixed setting. It always opens a new frame,
    // so the row store is refilled before any row reads it back; further
    // frame starts drop in now and then mid-row.
    task automatic run_frame(input logic [PRED_W-1:0] sel, input bit with_alpha,
                             input logic [CFG_W-1:0] width, input int count,
                             input int gap_pct, input bit hold_midway);
        int j;
        configure(sel, with_alpha, width);
        for (j = 0; j < count; j++)
        begin
            push_pixel(random_px(j == 0 || $urandom_range(0, 39) == 0));
            if (hold_midway && j == count / 2)
                drain();
            else
                pixel_gap(gap_pct);
        end
    endtask

    initial
    begin : stimulus
        int                 p;
        logic [CFG_W-1:0]   width;
        int                 count;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_PREDICTOR;
        cfg_data = '0;
        pixel_valid = 1'b0;
        pixel = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: left predictor, no alpha, full width. The first
        // pixel comes without a frame start and must still predict from 256.
        // Saturated samples drive the chroma differences to both ends, so the
        // residuals wrap around the nine-bit range.
        push_pixel(make_px(0, 0, 0, 0, 0));
        push_pixel(make_px(255, 255, 255, 255, 0));
        push_pixel(make_px(255, 0, 255, 0, 0));
        push_pixel(make_px(0, 255, 0, 255, 0));
        push_pixel(make_px(0, 0, 0, 0, 1));

        // One pixel per row with alpha coded: every pixel starts a row and is
        // predicted from the pixel above, whatever the predictor.
        configure(PRED_PLANE, 1'b1, 13'd1);
        push_pixel(make_px(10, 20, 30, 40, 1));
        push_pixel(make_px(200, 100, 50, 255, 0));
        push_pixel(make_px(0, 0, 0, 0, 0));
        push_pixel(make_px(255, 255, 255, 255, 0));

        // Two-pixel rows with the average predictor, then predictor zero,
        // which must behave the same way.
        configure(3'd7, 1'b1, 13'd2);
        push_pixel(make_px(0, 0, 0, 0, 1));
        push_pixel(make_px(255, 255, 255, 255, 0));
        push_pixel(make_px(255, 255, 255, 255, 0));
        push_pixel(make_px(0, 0, 0, 0, 0));
        push_pixel(make_px(128, 127, 129, 1, 0));
        push_pixel(make_px(0, 255, 255, 0, 0));
        configure(3'd0, 1'b0, 13'd2);
        push_pixel(make_px(255, 0, 0, 128, 1));
        push_pixel(make_px(0, 255, 0, 64, 0));
        push_pixel(make_px(0, 0, 255, 32, 0));
        push_pixel(make_px(255, 255, 0, 0, 0));

        // Random part: every predictor number, both alpha settings, narrow
        // rows and the width extremes. Full-width, zero and oversized widths
        // never finish a row, so those runs stay short.
        for (p = 0; p < 12; p++)
        begin
            case (p)
                0:       width = 13'd3;
                1:       width = 13'd5;
                2:       width = 13'd1;
                3:       width = 13'd8;
                4:       width = 13'd2;
                5:       width = 13'd16;
                6:       width = 13'd0;
                7:       width = 13'd4096;
                8:       width = 13'd7;
                9:       width = 13'd8191;
                10:      width = 13'd4;
                default: width = 13'd12;
            endcase
            count = (p == 6 || p == 7 || p == 9) ? 6 : 20;
            run_frame(p[PRED_W-1:0], 1'($urandom_range(0, 1)), width, count,
                      (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 30 : 60), p == 5);
        end

        // Closing stretch with both sides running flat out.
        steady = 1'b1;
        run_frame(PRED_ABOVE_HALF, 1'b1, 13'd6, 16, 0, 1'b0);

        drain();
        if (errors == 0)
            $display("lossless_jpeg_rct_pixel_encoder_tb: done, clean");
        else
            $display("lossless_jpeg_rct_pixel_encoder_tb: done, errors");
        $finish;
    end

endmodule
